@@ rtl/core/aad_pkg.sv @@
// Package for the area-average downscaler: widths, register indexes, controller
// states, divider jobs and the command and status structs.
// No dependencies.
package aad_pkg;

  localparam int MAX_SIDE = 4096;
  localparam int SIDE_W   = 13;
  localparam int COORD_W  = 12;
  localparam int PIX_W    = 8;
  localparam int SUM_W    = 32;
  localparam int CNT_W    = 25;
  localparam int CHANS    = 4;
  localparam int IDX_W    = 2;

  localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_SIZE_LIMIT    = 2'd2;

  typedef enum logic [2:0] {
    S_FIT_CHECK,
    S_DIV_START,
    S_DIV_WAIT,
    S_IDLE,
    S_PIX_UPDATE,
    S_DELIVER
  } state_t;

  typedef enum logic [2:0] {
    JOB_FIT_COLS,
    JOB_FIT_ROWS,
    JOB_COL_STEP,
    JOB_ROW_STEP,
    JOB_RED,
    JOB_GREEN,
    JOB_BLUE,
    JOB_ALPHA
  } job_t;

  typedef struct packed {
    logic pix_take;
    logic pix_update;
    logic div_start;
    logic div_store;
    logic fit_plain;
    logic out_load;
    job_t job;
  } cmd_t;

  typedef struct packed {
    logic cfg_written;
    logic scale_needed;
    logic produce;
    logic div_done;
    logic out_free;
  } status_t;

  // Zero counts as one, anything above the largest side saturates.
  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    if (v == '0) begin
      r = SIDE_W'(1);
    end else if (v > SIDE_W'(MAX_SIDE)) begin
      r = SIDE_W'(MAX_SIDE);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/aad_ram.sv @@
// Generic single-port-write, registered-read RAM.
// No dependencies.
module aad_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/aad_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on aad_pkg.
module aad_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [aad_pkg::SUM_W-1:0] num,
  input  logic [aad_pkg::CNT_W-1:0] den,
  output logic                      done,
  output logic [aad_pkg::SUM_W-1:0] quo,
  output logic [aad_pkg::CNT_W-1:0] rem
);

  logic [aad_pkg::SUM_W-1:0]         shreg;
  logic [aad_pkg::CNT_W-1:0]         divisor;
  logic [$clog2(aad_pkg::SUM_W)-1:0] step;
  logic                              active;
  logic [aad_pkg::CNT_W:0]           trial;
  logic [aad_pkg::CNT_W:0]           diff;

  assign trial = {rem, shreg[aad_pkg::SUM_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign quo   = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        step   <= '0;
      end else if (active) begin
        step <= step + 1'b1;
        if (step == '1) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg   <= num;
      divisor <= den;
      rem     <= '0;
    end else if (active) begin
      if (!diff[aad_pkg::CNT_W]) begin
        rem   <= diff[aad_pkg::CNT_W-1:0];
        shreg <= {shreg[aad_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem   <= trial[aad_pkg::CNT_W-1:0];
        shreg <= {shreg[aad_pkg::SUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ rtl/core/aad_dp.sv @@
// Datapath: configuration registers, window counters, column sum RAM,
// shared divider and the output register.
// Depends on aad_pkg, aad_ram and aad_div.
module aad_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [aad_pkg::IDX_W-1:0]         cfg_index,
  input  logic [aad_pkg::SIDE_W-1:0]        cfg_data,
  input  logic [aad_pkg::PIX_W-1:0]         in_red,
  input  logic [aad_pkg::PIX_W-1:0]         in_green,
  input  logic [aad_pkg::PIX_W-1:0]         in_blue,
  input  logic [aad_pkg::PIX_W-1:0]         in_alpha,
  input  logic                              out_stall,
  input  aad_pkg::cmd_t                     cmd,
  output aad_pkg::status_t                  status,
  output logic                              out_valid,
  output logic [aad_pkg::PIX_W-1:0]         mean_red,
  output logic [aad_pkg::PIX_W-1:0]         mean_green,
  output logic [aad_pkg::PIX_W-1:0]         mean_blue,
  output logic [aad_pkg::PIX_W-1:0]         mean_alpha,
  output logic [aad_pkg::COORD_W-1:0]       out_x,
  output logic [aad_pkg::COORD_W-1:0]       out_y,
  output logic [aad_pkg::SIDE_W-1:0]        scaled_width,
  output logic [aad_pkg::SIDE_W-1:0]        scaled_height,
  output logic                              last_pixel
);

  localparam int SW = aad_pkg::SIDE_W;
  localparam int CW = aad_pkg::COORD_W;
  localparam int RAM_W = aad_pkg::SUM_W * aad_pkg::CHANS;

  logic [SW-1:0] src_w, src_h, lim;
  logic [SW-1:0] fitc, fitr;
  logic [SW-1:0] cq, rq;
  logic [CW-1:0] cr, rr;
  logic [CW-1:0] src_col, src_row, dest_col, dest_row;
  logic [CW-1:0] cws, rws, col_rem, row_rem;
  logic [SW-1:0] cwe, rwe;

  logic [aad_pkg::PIX_W-1:0]   pix      [aad_pkg::CHANS];
  logic [aad_pkg::SUM_W-1:0]   new_sum  [aad_pkg::CHANS];
  logic [aad_pkg::SUM_W-1:0]   sum_hold [aad_pkg::CHANS];
  logic [aad_pkg::PIX_W-1:0]   mean_hold[aad_pkg::CHANS];
  logic [aad_pkg::CNT_W-1:0]   count;
  logic [CW-1:0]               res_x, res_y;
  logic                        res_last;

  logic [RAM_W-1:0] rdata, wdata;

  logic [SW-1:0] longest;
  logic          first, col_end, row_end, col_wrap, img_end;
  logic [SW-1:0] cs, rs, cwe_step, rwe_step;
  logic          c_carry, r_carry;
  logic [CW-1:0] col_rem_step, row_rem_step;
  logic [2*SW-1:0] area;

  logic [aad_pkg::SUM_W-1:0] div_num;
  logic [aad_pkg::CNT_W-1:0] div_den;
  logic                      div_done;
  logic [aad_pkg::SUM_W-1:0] div_quo;
  logic [aad_pkg::CNT_W-1:0] div_rem;
  logic [SW-1:0]             quo_side;

  // Configuration registers hold clamped values.
  always_ff @(posedge clk) begin
    if (rst) begin
      src_w <= SW'(1);
      src_h <= SW'(1);
      lim   <= SW'(aad_pkg::MAX_SIDE);
    end else if (cfg_we) begin
      unique case (cfg_index)
        aad_pkg::REG_SOURCE_WIDTH:  src_w <= aad_pkg::clamp_side(cfg_data);
        aad_pkg::REG_SOURCE_HEIGHT: src_h <= aad_pkg::clamp_side(cfg_data);
        aad_pkg::REG_SIZE_LIMIT:    lim   <= aad_pkg::clamp_side(cfg_data);
        default: ;
      endcase
    end
  end

  assign longest = (src_w > src_h) ? src_w : src_h;

  // Window bookkeeping for the pixel being updated.
  assign first    = (src_row == rws) && (src_col == cws);
  assign col_end  = ({1'b0, src_col} + SW'(1)) >= cwe;
  assign row_end  = ({1'b0, src_row} + SW'(1)) >= rwe;
  assign col_wrap = ({1'b0, src_col} + SW'(1)) >= src_w;
  assign img_end  = ({1'b0, src_row} + SW'(1)) >= src_h;

  // Next window end: add the whole quotient, and one more when the running
  // remainder reaches or passes the output size.
  assign cs           = {1'b0, col_rem} + {1'b0, cr};
  assign c_carry      = cs >= fitc;
  assign col_rem_step = c_carry ? CW'(cs - fitc) : cs[CW-1:0];
  assign cwe_step     = cwe + cq + SW'(c_carry);
  assign rs           = {1'b0, row_rem} + {1'b0, rr};
  assign r_carry      = rs >= fitr;
  assign row_rem_step = r_carry ? CW'(rs - fitr) : rs[CW-1:0];
  assign rwe_step     = rwe + rq + SW'(r_carry);

  assign area = (cwe - {1'b0, cws}) * (rwe - {1'b0, rws});

  always_comb begin
    for (int c = 0; c < aad_pkg::CHANS; c++) begin
      if (first) begin
        new_sum[c] = aad_pkg::SUM_W'(pix[c]);
      end else begin
        new_sum[c] = rdata[c*aad_pkg::SUM_W +: aad_pkg::SUM_W] + aad_pkg::SUM_W'(pix[c]);
      end
      wdata[c*aad_pkg::SUM_W +: aad_pkg::SUM_W] = new_sum[c];
    end
  end

  aad_ram #(
    .WIDTH(RAM_W),
    .DEPTH(aad_pkg::MAX_SIDE)
  ) u_sums (
    .clk  (clk),
    .we   (cmd.pix_update),
    .waddr(dest_col),
    .wdata(wdata),
    .raddr(dest_col),
    .rdata(rdata)
  );

  always_comb begin
    unique case (cmd.job)
      aad_pkg::JOB_FIT_COLS: begin
        div_num = aad_pkg::SUM_W'(src_w) * aad_pkg::SUM_W'(lim);
        div_den = aad_pkg::CNT_W'(longest);
      end
      aad_pkg::JOB_FIT_ROWS: begin
        div_num = aad_pkg::SUM_W'(src_h) * aad_pkg::SUM_W'(lim);
        div_den = aad_pkg::CNT_W'(longest);
      end
      aad_pkg::JOB_COL_STEP: begin
        div_num = aad_pkg::SUM_W'(src_w);
        div_den = aad_pkg::CNT_W'(fitc);
      end
      aad_pkg::JOB_ROW_STEP: begin
        div_num = aad_pkg::SUM_W'(src_h);
        div_den = aad_pkg::CNT_W'(fitr);
      end
      aad_pkg::JOB_RED: begin
        div_num = sum_hold[0] + aad_pkg::SUM_W'(count >> 1);
        div_den = count;
      end
      aad_pkg::JOB_GREEN: begin
        div_num = sum_hold[1] + aad_pkg::SUM_W'(count >> 1);
        div_den = count;
      end
      aad_pkg::JOB_BLUE: begin
        div_num = sum_hold[2] + aad_pkg::SUM_W'(count >> 1);
        div_den = count;
      end
      aad_pkg::JOB_ALPHA: begin
        div_num = sum_hold[3] + aad_pkg::SUM_W'(count >> 1);
        div_den = count;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  aad_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  assign quo_side = (div_quo == '0) ? SW'(1) : div_quo[SW-1:0];

  // Fitted size, step constants, stream counters, the input pixel, the closed window's sums and the channel means.
  always_ff @(posedge clk) begin
    if (cmd.fit_plain) begin
      fitc <= src_w;
      fitr <= src_h;
    end
    if (cmd.div_store) begin
      unique case (cmd.job)
        aad_pkg::JOB_FIT_COLS: fitc <= quo_side;
        aad_pkg::JOB_FIT_ROWS: fitr <= quo_side;
        aad_pkg::JOB_COL_STEP: begin
          cq <= div_quo[SW-1:0];
          cr <= div_rem[CW-1:0];
        end
        aad_pkg::JOB_ROW_STEP: begin
          rq       <= div_quo[SW-1:0];
          rr       <= div_rem[CW-1:0];
          src_col  <= '0;
          src_row  <= '0;
          dest_col <= '0;
          dest_row <= '0;
          cws      <= '0;
          cwe      <= cq;
          col_rem  <= cr;
          rws      <= '0;
          rwe      <= div_quo[SW-1:0];
          row_rem  <= div_rem[CW-1:0];
        end
        aad_pkg::JOB_RED:   mean_hold[0] <= div_quo[aad_pkg::PIX_W-1:0];
        aad_pkg::JOB_GREEN: mean_hold[1] <= div_quo[aad_pkg::PIX_W-1:0];
        aad_pkg::JOB_BLUE:  mean_hold[2] <= div_quo[aad_pkg::PIX_W-1:0];
        aad_pkg::JOB_ALPHA: mean_hold[3] <= div_quo[aad_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
    if (cmd.pix_take) begin
      pix[0] <= in_red;
      pix[1] <= in_green;
      pix[2] <= in_blue;
      pix[3] <= in_alpha;
    end
    if (cmd.pix_update) begin
      if (col_end && row_end) begin
        for (int c = 0; c < aad_pkg::CHANS; c++) begin
          sum_hold[c] <= new_sum[c];
        end
        count    <= area[aad_pkg::CNT_W-1:0];
        res_x    <= dest_col;
        res_y    <= dest_row;
        res_last <= ({1'b0, dest_col} + SW'(1) >= fitc) &&
                    ({1'b0, dest_row} + SW'(1) >= fitr);
      end
      if (col_wrap) begin
        src_col  <= '0;
        dest_col <= '0;
        cws      <= '0;
        cwe      <= cq;
        col_rem  <= cr;
        if (img_end) begin
          src_row  <= '0;
          dest_row <= '0;
          rws      <= '0;
          rwe      <= rq;
          row_rem  <= rr;
        end else begin
          src_row <= src_row + 1'b1;
          if (row_end) begin
            dest_row <= dest_row + 1'b1;
            rws      <= rwe[CW-1:0];
            rwe      <= rwe_step;
            row_rem  <= row_rem_step;
          end
        end
      end else begin
        src_col <= src_col + 1'b1;
        if (col_end) begin
          dest_col <= dest_col + 1'b1;
          cws      <= cwe[CW-1:0];
          cwe      <= cwe_step;
          col_rem  <= col_rem_step;
        end
      end
    end
  end

  // Output register: a new result may be loaded as the old one transfers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mean_red      <= mean_hold[0];
      mean_green    <= mean_hold[1];
      mean_blue     <= mean_hold[2];
      mean_alpha    <= mean_hold[3];
      out_x         <= res_x;
      out_y         <= res_y;
      scaled_width  <= fitc;
      scaled_height <= fitr;
      last_pixel    <= res_last;
    end
  end

  assign status.cfg_written  = cfg_we && (cfg_index == aad_pkg::REG_SOURCE_WIDTH ||
                                          cfg_index == aad_pkg::REG_SOURCE_HEIGHT ||
                                          cfg_index == aad_pkg::REG_SIZE_LIMIT);
  assign status.scale_needed = longest > lim;
  assign status.produce      = col_end && row_end;
  assign status.div_done     = div_done;
  assign status.out_free     = !out_valid || !out_stall;

endmodule

@@ rtl/core/aad_ctrl.sv @@
// Controller state machine: restart sequence after reset or a register write,
// per-pixel update, the four mean divisions and result hand-over.
// Depends on aad_pkg.
module aad_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  aad_pkg::status_t status,
  output aad_pkg::cmd_t    cmd,
  output logic             in_stall
);

  aad_pkg::state_t state, state_next;
  aad_pkg::job_t   job, job_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aad_pkg::S_FIT_CHECK;
      job   <= aad_pkg::JOB_FIT_COLS;
    end else begin
      state <= state_next;
      job   <= job_next;
    end
  end

  always_comb begin
    state_next = state;
    job_next   = job;
    if (status.cfg_written) begin
      state_next = aad_pkg::S_FIT_CHECK;
    end else begin
      unique case (state)
        aad_pkg::S_FIT_CHECK: begin
          state_next = aad_pkg::S_DIV_START;
          job_next   = status.scale_needed ? aad_pkg::JOB_FIT_COLS : aad_pkg::JOB_COL_STEP;
        end
        aad_pkg::S_DIV_START: state_next = aad_pkg::S_DIV_WAIT;
        aad_pkg::S_DIV_WAIT: begin
          if (status.div_done) begin
            state_next = aad_pkg::S_DIV_START;
            unique case (job)
              aad_pkg::JOB_FIT_COLS: job_next = aad_pkg::JOB_FIT_ROWS;
              aad_pkg::JOB_FIT_ROWS: job_next = aad_pkg::JOB_COL_STEP;
              aad_pkg::JOB_COL_STEP: job_next = aad_pkg::JOB_ROW_STEP;
              aad_pkg::JOB_ROW_STEP: state_next = aad_pkg::S_IDLE;
              aad_pkg::JOB_RED:      job_next = aad_pkg::JOB_GREEN;
              aad_pkg::JOB_GREEN:    job_next = aad_pkg::JOB_BLUE;
              aad_pkg::JOB_BLUE:     job_next = aad_pkg::JOB_ALPHA;
              aad_pkg::JOB_ALPHA:    state_next = aad_pkg::S_DELIVER;
              default:               state_next = aad_pkg::S_FIT_CHECK;
            endcase
          end
        end
        aad_pkg::S_IDLE: begin
          if (in_valid) begin
            state_next = aad_pkg::S_PIX_UPDATE;
          end
        end
        aad_pkg::S_PIX_UPDATE: begin
          if (status.produce) begin
            state_next = aad_pkg::S_DIV_START;
            job_next   = aad_pkg::JOB_RED;
          end else begin
            state_next = aad_pkg::S_IDLE;
          end
        end
        aad_pkg::S_DELIVER: begin
          if (status.out_free) begin
            state_next = aad_pkg::S_IDLE;
          end
        end
        default: state_next = aad_pkg::S_FIT_CHECK;
      endcase
    end
  end

  always_comb begin
    cmd.pix_take   = (state == aad_pkg::S_IDLE) && in_valid;
    cmd.pix_update = (state == aad_pkg::S_PIX_UPDATE);
    cmd.div_start  = (state == aad_pkg::S_DIV_START);
    cmd.div_store  = (state == aad_pkg::S_DIV_WAIT) && status.div_done;
    cmd.fit_plain  = (state == aad_pkg::S_FIT_CHECK) && !status.scale_needed;
    cmd.out_load   = (state == aad_pkg::S_DELIVER) && status.out_free;
    cmd.job        = job;
    in_stall       = (state != aad_pkg::S_IDLE);
  end

endmodule

@@ rtl/core/area_average_downscale_top.sv @@
// Top level of the area-average downscaler: controller plus datapath.
// Depends on aad_pkg, aad_ctrl and aad_dp.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   config   | cfg_we             | cfg_index, cfg_data
//   pixel in | in_valid/in_stall  | in_red, in_green, in_blue, in_alpha
//   result   | out_valid/out_stall| means, out_x/out_y, scaled size, last
//
// A pixel that closes no window is transferred while the sum RAM is read, then
// the column sum gets its read-modify-write. A pixel that closes a window adds
// four divisions on the shared radix-2 divider, each a start state and a wait
// for completion, and then the hand-over of the result. After reset and after
// every register write a check state is followed by up to four divisions with
// in_stall high. A waiting result only holds the block once the next result
// is ready.
module area_average_downscale_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [aad_pkg::IDX_W-1:0]         cfg_index,
  input  logic [aad_pkg::SIDE_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [aad_pkg::PIX_W-1:0]         in_red,
  input  logic [aad_pkg::PIX_W-1:0]         in_green,
  input  logic [aad_pkg::PIX_W-1:0]         in_blue,
  input  logic [aad_pkg::PIX_W-1:0]         in_alpha,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [aad_pkg::PIX_W-1:0]         mean_red,
  output logic [aad_pkg::PIX_W-1:0]         mean_green,
  output logic [aad_pkg::PIX_W-1:0]         mean_blue,
  output logic [aad_pkg::PIX_W-1:0]         mean_alpha,
  output logic [aad_pkg::COORD_W-1:0]       out_x,
  output logic [aad_pkg::COORD_W-1:0]       out_y,
  output logic [aad_pkg::SIDE_W-1:0]        scaled_width,
  output logic [aad_pkg::SIDE_W-1:0]        scaled_height,
  output logic                              last_pixel
);

  aad_pkg::cmd_t    cmd;
  aad_pkg::status_t status;

  aad_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .status  (status),
    .cmd     (cmd),
    .in_stall(in_stall)
  );

  aad_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .in_alpha     (in_alpha),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .mean_red     (mean_red),
    .mean_green   (mean_green),
    .mean_blue    (mean_blue),
    .mean_alpha   (mean_alpha),
    .out_x        (out_x),
    .out_y        (out_y),
    .scaled_width (scaled_width),
    .scaled_height(scaled_height),
    .last_pixel   (last_pixel)
  );

endmodule

@@ rtl/core/aad_checker.sv @@
// Port-level checks for the area-average downscaler, bound to the top level.
// Depends on aad_pkg and area_average_downscale_top.
module aad_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cfg_we,
  input logic [aad_pkg::IDX_W-1:0]   cfg_index,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [aad_pkg::PIX_W-1:0]   mean_red,
  input logic [aad_pkg::COORD_W-1:0] out_x,
  input logic [aad_pkg::COORD_W-1:0] out_y,
  input logic [aad_pkg::SIDE_W-1:0]  scaled_width,
  input logic [aad_pkg::SIDE_W-1:0]  scaled_height,
  input logic                        last_pixel
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(mean_red) && $stable(out_x))
    else $error("stalled result changed");

  a_coord_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, out_x} < scaled_width) && ({1'b0, out_y} < scaled_height))
    else $error("output coordinate outside the fitted size");

  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_pixel |->
      ({1'b0, out_x} + 13'd1 == scaled_width) && ({1'b0, out_y} + 13'd1 == scaled_height))
    else $error("last pixel flag away from the bottom-right corner");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == aad_pkg::REG_SOURCE_WIDTH ||
               cfg_index == aad_pkg::REG_SOURCE_HEIGHT ||
               cfg_index == aad_pkg::REG_SIZE_LIMIT) |=> in_stall)
    else $error("pixels accepted straight after a register write");

endmodule

bind area_average_downscale_top aad_checker u_aad_checker (
  .clk          (clk),
  .rst          (rst),
  .cfg_we       (cfg_we),
  .cfg_index    (cfg_index),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .mean_red     (mean_red),
  .out_x        (out_x),
  .out_y        (out_y),
  .scaled_width (scaled_width),
  .scaled_height(scaled_height),
  .last_pixel   (last_pixel)
);
